/* rtl/core/cwbsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwbsc_pkg
// Shared types and constants of the CLOCK write-back sector cache.
// ----------------------------------------------------------------------------
package cwbsc_pkg;

    localparam int DEF_LINES = 32;
    localparam int NCOUNT    = 7;

    typedef enum logic [2:0] {
        REQ_READ  = 3'd0,
        REQ_WRITE = 3'd1,
        REQ_FLUSH = 3'd2,
        REQ_RDCNT = 3'd3,
        REQ_CLR   = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        KIND_DONE = 2'd0,
        KIND_WB   = 2'd1,
        KIND_CNT  = 2'd2
    } kind_t;

    localparam logic [2:0] CNT_HIT   = 3'd0;
    localparam logic [2:0] CNT_MISS  = 3'd1;
    localparam logic [2:0] CNT_EVICT = 3'd2;
    localparam logic [2:0] CNT_WRITE = 3'd3;
    localparam logic [2:0] CNT_WBACK = 3'd4;
    localparam logic [2:0] CNT_DIRTY = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SWEEP,
        ST_FLUSH,
        ST_COUNT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] sector;
        logic        fill_ok;
        logic [2:0]  counter_select;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] target_sector;
        logic [4:0]  line_index;
        logic        hit;
        logic        fill_needed;
        logic        status;
        logic [31:0] counter_value;
        logic        last;
    } out_word_t;

endpackage

/* rtl/core/cwbsc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwbsc_in_if / cwbsc_out_if
// Valid/ready channels for request and result words.
// ----------------------------------------------------------------------------
interface cwbsc_in_if;
    logic                     valid;
    logic                     ready;
    cwbsc_pkg::in_word_t      data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cwbsc_out_if;
    logic                     valid;
    logic                     ready;
    cwbsc_pkg::out_word_t     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/clock_write_back_sector_cache.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_write_back_sector_cache
// Fully associative write-back sector cache tag/policy controller with
// CLOCK replacement. One shared compare unit scans a line per unstalled cycle.
// ----------------------------------------------------------------------------
//  channel   dir   word
//  req       in    req_type, sector, fill_ok, counter_select
//  rsp       out   kind, target_sector, line_index, hit, fill_needed,
//                  status, counter_value, last
//
//  One line is examined per cycle by the shared tag compare; sweep, flush
//  and emit steps wait while rsp holds an untaken word. A hit ends the
//  lookup at its line, a miss scans all lines and sweeps the CLOCK hand,
//  flush and counter reads walk all lines, clear and unused requests skip
//  the scan. The final word then loads into rsp; req is ready again the cycle
//  after. Reset clears all line state, the hand and the counters.
// ----------------------------------------------------------------------------
module clock_write_back_sector_cache #(
    parameter int LINES = cwbsc_pkg::DEF_LINES
) (
    input  logic        clk,
    input  logic        rst_n,
    cwbsc_in_if.sink    req,
    cwbsc_out_if.source rsp
);
    import cwbsc_pkg::*;

    localparam int IW = (LINES > 1) ? $clog2(LINES) : 1;

    logic [LINES-1:0]  valid_reg, valid_next;
    logic [LINES-1:0]  dirty_reg, dirty_next;
    logic [LINES-1:0]  ref_reg, ref_next;
    logic [31:0]       tag_reg [LINES];
    logic              tag_we;
    logic [IW-1:0]     tag_wa;
    logic [IW-1:0]     hand_reg, hand_next;
    logic [31:0]       cnt_reg [NCOUNT];
    logic [31:0]       cnt_next [NCOUNT];

    state_t            state_reg, state_next;
    in_word_t          cur_reg, cur_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [IW:0]       dcnt_reg, dcnt_next;
    out_word_t         out_reg, out_next;
    out_word_t         hold_reg, hold_next;
    logic              out_valid_reg, out_valid_next;

    logic [IW-1:0]     idx_inc, hand_inc;
    logic              hit_now;
    logic [4:0]        idx5, hand5;
    logic              out_free;
    logic [IW:0]       dsum;
    logic [31:0]       sel_val;

    assign idx_inc  = (idx_reg == IW'(LINES - 1)) ? '0 : idx_reg + 1'b1;
    assign hand_inc = (hand_reg == IW'(LINES - 1)) ? '0 : hand_reg + 1'b1;
    assign hit_now  = valid_reg[idx_reg] && (tag_reg[idx_reg] == cur_reg.sector);
    assign idx5     = 5'(idx_reg);
    assign hand5    = 5'(hand_reg);
    assign dsum     = dcnt_reg + (IW+1)'(valid_reg[idx_reg] && dirty_reg[idx_reg]);

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;
    assign out_free  = !out_valid_reg || rsp.ready;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    always_comb
    begin
        unique case (cur_reg.counter_select) inside
            CNT_HIT, CNT_MISS, CNT_EVICT, CNT_WRITE, CNT_WBACK:
                sel_val = cnt_reg[cur_reg.counter_select];
            CNT_DIRTY:
                sel_val = 32'(dsum);
            default:
                sel_val = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            ref_reg       <= '0;
            hand_reg      <= '0;
            cur_reg       <= '0;
            idx_reg       <= '0;
            dcnt_reg      <= '0;
            out_reg       <= '0;
            hold_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NCOUNT; i++)
                cnt_reg[i] <= '0;
            for (int i = 0; i < LINES; i++)
                tag_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            dirty_reg     <= dirty_next;
            ref_reg       <= ref_next;
            hand_reg      <= hand_next;
            cur_reg       <= cur_next;
            idx_reg       <= idx_next;
            dcnt_reg      <= dcnt_next;
            out_reg       <= out_next;
            hold_reg      <= hold_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < NCOUNT; i++)
                cnt_reg[i] <= cnt_next[i];
            if (tag_we)
                tag_reg[tag_wa] <= cur_reg.sector;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        dirty_next     = dirty_reg;
        ref_next       = ref_reg;
        hand_next      = hand_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        dcnt_next      = dcnt_reg;
        out_next       = out_reg;
        hold_next      = hold_reg;
        out_valid_next = out_valid_reg;
        tag_we         = 1'b0;
        tag_wa         = hand_reg;
        for (int i = 0; i < NCOUNT; i++)
            cnt_next[i] = cnt_reg[i];
        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cur_next  = req.data;
                    idx_next  = '0;
                    dcnt_next = '0;
                    unique case (req.data.req_type) inside
                        REQ_READ, REQ_WRITE: state_next = ST_LOOK;
                        REQ_FLUSH:           state_next = ST_FLUSH;
                        REQ_RDCNT:           state_next = ST_COUNT;
                        default:
                        begin
                            if (req.data.req_type == REQ_CLR)
                                for (int i = 0; i < NCOUNT; i++)
                                    cnt_next[i] = '0;
                            hold_next  = '{kind: KIND_DONE, last: 1'b1, default: '0};
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_LOOK:
            begin
                if (hit_now)
                begin
                    cnt_next[CNT_HIT] = sat_inc(cnt_reg[CNT_HIT]);
                    ref_next[idx_reg] = 1'b1;
                    if (cur_reg.req_type == REQ_WRITE)
                    begin
                        dirty_next[idx_reg] = 1'b1;
                        cnt_next[CNT_WRITE] = sat_inc(cnt_reg[CNT_WRITE]);
                    end
                    hold_next  = '{kind: KIND_DONE, target_sector: cur_reg.sector,
                                   line_index: idx5, hit: 1'b1, last: 1'b1,
                                   default: '0};
                    state_next = ST_EMIT;
                end
                else if (idx_reg == IW'(LINES - 1))
                begin
                    cnt_next[CNT_MISS] = sat_inc(cnt_reg[CNT_MISS]);
                    state_next = ST_SWEEP;
                end
                else
                    idx_next = idx_inc;
            end
            ST_SWEEP:
            begin
                if (out_free)
                begin
                    hand_next = hand_inc;
                    if (valid_reg[hand_reg] && ref_reg[hand_reg])
                        ref_next[hand_reg] = 1'b0;
                    else
                    begin
                        if (valid_reg[hand_reg])
                        begin
                            cnt_next[CNT_EVICT] = sat_inc(cnt_reg[CNT_EVICT]);
                            if (dirty_reg[hand_reg])
                            begin
                                cnt_next[CNT_WBACK] = sat_inc(cnt_reg[CNT_WBACK]);
                                out_next = '{kind: KIND_WB,
                                             target_sector: tag_reg[hand_reg],
                                             line_index: hand5, default: '0};
                                out_valid_next = 1'b1;
                            end
                        end
                        tag_we = 1'b1;
                        tag_wa = hand_reg;
                        if (cur_reg.req_type == REQ_WRITE)
                        begin
                            valid_next[hand_reg] = 1'b1;
                            dirty_next[hand_reg] = 1'b1;
                            ref_next[hand_reg]   = 1'b1;
                            cnt_next[CNT_WRITE]  = sat_inc(cnt_reg[CNT_WRITE]);
                        end
                        else
                        begin
                            valid_next[hand_reg] = cur_reg.fill_ok;
                            dirty_next[hand_reg] = 1'b0;
                            ref_next[hand_reg]   = cur_reg.fill_ok;
                        end
                        hold_next  = '{kind: KIND_DONE, target_sector: cur_reg.sector,
                                       line_index: hand5,
                                       fill_needed: (cur_reg.req_type == REQ_READ),
                                       status: (cur_reg.req_type == REQ_READ)
                                               && !cur_reg.fill_ok,
                                       last: 1'b1, default: '0};
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    if (valid_reg[idx_reg] && dirty_reg[idx_reg])
                    begin
                        dirty_next[idx_reg] = 1'b0;
                        cnt_next[CNT_WBACK] = sat_inc(cnt_reg[CNT_WBACK]);
                        out_next = '{kind: KIND_WB, target_sector: tag_reg[idx_reg],
                                     line_index: idx5, default: '0};
                        out_valid_next = 1'b1;
                    end
                    if (idx_reg == IW'(LINES - 1))
                    begin
                        hold_next  = '{kind: KIND_DONE, last: 1'b1, default: '0};
                        state_next = ST_EMIT;
                    end
                    else
                        idx_next = idx_inc;
                end
            end
            ST_COUNT:
            begin
                dcnt_next = dsum;
                if (idx_reg == IW'(LINES - 1))
                begin
                    cnt_next[CNT_DIRTY] = 32'(dsum);
                    hold_next  = '{kind: KIND_CNT, counter_value: sel_val, last: 1'b1,
                                   default: '0};
                    state_next = ST_EMIT;
                end
                else
                    idx_next = idx_inc;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_next       = hold_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule
